/* design/vosd_pkg.sv */
// Package for the volume overlay step and fade controller.
// Phase, item kind and register codes, fixed-point constants, pose unit structs.
// No dependencies.
`default_nettype none
package vosd_pkg;

   localparam logic [1:0] PH_HIDDEN = 2'd0;
   localparam logic [1:0] PH_INTRO  = 2'd1;
   localparam logic [1:0] PH_HOLD   = 2'd2;
   localparam logic [1:0] PH_OUTRO  = 2'd3;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_UP     = 3'd1;
   localparam logic [2:0] KIND_DOWN   = 3'd2;
   localparam logic [2:0] KIND_MUTE   = 3'd3;
   localparam logic [2:0] KIND_REPORT = 3'd4;

   localparam logic [2:0] CSR_ENABLE = 3'd0;
   localparam logic [2:0] CSR_INTRO  = 3'd1;
   localparam logic [2:0] CSR_HOLD   = 3'd2;
   localparam logic [2:0] CSR_OUTRO  = 3'd3;

   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic signed [12:0] HIDDEN_OFFSET = -13'sd3072;
   localparam logic [21:0] ELAPSED_MAX = 22'h3FFFFF;
   localparam logic [16:0] COEF_SU2    = 17'd43254;
   localparam logic [16:0] COEF_S2U    = 17'd70779;
   localparam logic [18:0] EASE_TOL    = 19'd3;

   typedef struct packed {
      logic [1:0]         phase;
      logic [21:0]        elapsed;
      logic [21:0]        len;
      logic [16:0]        start_op;
      logic signed [12:0] start_off;
   } pose_req_type;

   typedef struct packed {
      logic [16:0]        op;
      logic signed [12:0] off;
   } pose_rsp_type;

endpackage
`default_nettype wire

/* design/volume_osd_step_and_fade_controller_core.sv */
// Volume overlay controller top level: step and mute rules, phase sequencer, result register.
// Depends on vosd_pkg and vosd_pose.
//
// Use: req_* carries one item (tick, up, down, toggle mute, system report); each transfer
// yields exactly one rsp_* item holding the pose, phase, step, mute flag and bar fill after
// the item. csr_* writes the enable and the three phase lengths; csr_ready is always high.
// Flow: an item whose phase is hidden or hold gets its fixed pose from the pose unit. In intro or
// outro the pose unit runs a progress divide (skipped once elapsed reaches the length), up to
// EASE_ITERATIONS bisection passes on the multiplier, then the cube and the blend. An item
// that begins a phase from an animated pose runs the pose unit twice, once to capture the
// start pose. One item is in work at a time; req_stall is high meanwhile.
// vosd_pose does all of its products on one shared multiplier.
// Reset: phase hidden, step 8 (STEP_COUNT if smaller), unmuted, registers at their defaults, result register empty.
// A stalled rsp holds its value; the next item is still taken and its result waits
// for the register to empty.
`default_nettype none
module volume_osd_step_and_fade_controller_core #(
   parameter int STEP_COUNT = 16,
   parameter int EASE_ITERATIONS = 10,
   localparam int SW = $clog2(STEP_COUNT + 1)
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire  [2:0]        req_kind,
   input  wire  [4:0]        req_report_step,
   input  wire               req_report_muted,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [16:0]       rsp_opacity,
   output logic signed [12:0] rsp_offset_y,
   output logic [1:0]        rsp_phase,
   output logic [SW-1:0]     rsp_volume_step,
   output logic              rsp_is_muted,
   output logic [7:0]        rsp_bar_fill,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [2:0]        csr_index,
   input  wire  [21:0]       csr_data
);

   localparam logic [SW-1:0] STEP_MAX = SW'(STEP_COUNT);
   localparam logic [SW-1:0] STEP_RESET = SW'((STEP_COUNT < 8) ? STEP_COUNT : 8);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CAP  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]  st_ff, st_in;
   logic        go_ff, go_in;
   logic        cap_intro_ff, cap_intro_in;
   logic [1:0]  phase_ff, phase_in;
   logic [21:0] elapsed_ff, elapsed_in;
   logic [16:0] sop_ff, sop_in;
   logic signed [12:0] soff_ff, soff_in;
   logic [SW-1:0] step_ff, step_in, last_ff, last_in;
   logic        mute_ff, mute_in;
   logic        en_ff;
   logic [21:0] intro_ff, hold_ff, outro_ff;
   logic        rsp_valid_ff;
   logic [16:0] rsp_op_ff;
   logic signed [12:0] rsp_off_ff;
   logic [1:0]  rsp_phase_ff;
   logic [SW-1:0] rsp_step_ff;
   logic        rsp_mute_ff;
   logic [7:0]  rsp_bar_ff;

   logic [7:0]  bar_lut [STEP_COUNT+1];
   vosd_pkg::pose_req_type pose_req;
   vosd_pkg::pose_rsp_type pose_rsp;
   logic        pose_done, pose_busy;
   logic        req_xfer, rsp_load;

   for (genvar g = 0; g <= STEP_COUNT; g++) begin : g_bar
      assign bar_lut[g] = 8'((g * 240 + STEP_COUNT / 2) / STEP_COUNT);
   end

   assign pose_req.phase = phase_ff;
   assign pose_req.elapsed = elapsed_ff;
   assign pose_req.len = (phase_ff == vosd_pkg::PH_INTRO) ? intro_ff : outro_ff;
   assign pose_req.start_op = sop_ff;
   assign pose_req.start_off = soff_ff;

   vosd_pose #(
      .EASE_ITERATIONS(EASE_ITERATIONS)
   ) u_pose (
      .clock(clock),
      .reset(reset),
      .go(go_ff),
      .req(pose_req),
      .done(pose_done),
      .busy(pose_busy),
      .rsp(pose_rsp)
   );

   assign req_stall = st_ff != S_IDLE;
   assign req_xfer = req_valid && !req_stall;
   assign rsp_load = (st_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   always_comb begin
      logic [21:0] el;
      logic [SW-1:0] stp;
      logic        m;
      st_in = st_ff;
      cap_intro_in = cap_intro_ff;
      phase_in = phase_ff;
      elapsed_in = elapsed_ff;
      sop_in = sop_ff;
      soff_in = soff_ff;
      step_in = step_ff;
      mute_in = mute_ff;
      last_in = last_ff;
      el = (elapsed_ff < vosd_pkg::ELAPSED_MAX) ? elapsed_ff + 22'd1 : elapsed_ff;
      stp = step_ff;
      m = mute_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (req_xfer) begin
               st_in = S_FIN;
               if (req_kind == vosd_pkg::KIND_REPORT) begin
                  stp = (32'(req_report_step) > STEP_COUNT) ? STEP_MAX : SW'(req_report_step);
                  step_in = stp;
                  mute_in = req_report_muted;
                  if (stp != '0) last_in = stp;
               end else if (en_ff && req_kind == vosd_pkg::KIND_TICK) begin
                  elapsed_in = el;
                  if (phase_ff == vosd_pkg::PH_INTRO && el >= intro_ff) begin
                     cap_intro_in = 1'b0;
                     st_in = S_CAP;
                  end else if (phase_ff == vosd_pkg::PH_HOLD && el >= hold_ff) begin
                     sop_in = vosd_pkg::ONE_Q16;
                     soff_in = '0;
                     elapsed_in = '0;
                     phase_in = (outro_ff == '0) ? vosd_pkg::PH_HIDDEN : vosd_pkg::PH_OUTRO;
                  end else if (phase_ff == vosd_pkg::PH_OUTRO && el >= outro_ff) begin
                     phase_in = vosd_pkg::PH_HIDDEN;
                  end
               end else if (en_ff && (req_kind == vosd_pkg::KIND_UP ||
                                      req_kind == vosd_pkg::KIND_DOWN ||
                                      req_kind == vosd_pkg::KIND_MUTE)) begin
                  if (req_kind == vosd_pkg::KIND_MUTE) begin
                     m = !mute_ff;
                     if (!m && stp == '0) stp = last_ff;
                  end else begin
                     if (m) begin
                        m = 1'b0;
                        stp = last_ff;
                     end
                     if (req_kind == vosd_pkg::KIND_UP) begin
                        if (stp < STEP_MAX) stp = stp + 1'b1;
                        last_in = stp;
                     end else begin
                        if (stp != '0) stp = stp - 1'b1;
                        if (stp != '0) last_in = stp;
                     end
                  end
                  step_in = stp;
                  mute_in = m;
                  if (phase_ff == vosd_pkg::PH_HIDDEN) begin
                     sop_in = '0;
                     soff_in = vosd_pkg::HIDDEN_OFFSET;
                     phase_in = vosd_pkg::PH_INTRO;
                     elapsed_in = '0;
                  end else if (phase_ff == vosd_pkg::PH_OUTRO) begin
                     cap_intro_in = 1'b1;
                     st_in = S_CAP;
                  end else if (phase_ff == vosd_pkg::PH_HOLD) begin
                     elapsed_in = '0;
                  end
               end
            end
         end
         S_CAP: begin
            if (pose_done) begin
               sop_in = pose_rsp.op;
               soff_in = pose_rsp.off;
               elapsed_in = '0;
               st_in = S_FIN;
               if (cap_intro_ff) begin
                  phase_in = vosd_pkg::PH_INTRO;
               end else if (hold_ff != '0) begin
                  phase_in = vosd_pkg::PH_HOLD;
               end else begin
                  sop_in = vosd_pkg::ONE_Q16;
                  soff_in = '0;
                  phase_in = (outro_ff == '0) ? vosd_pkg::PH_HIDDEN : vosd_pkg::PH_OUTRO;
               end
            end
         end
         S_FIN: begin
            if (pose_done) st_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign go_in = (st_in == S_CAP || st_in == S_FIN) && (st_in != st_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         go_ff <= 1'b0;
         cap_intro_ff <= 1'b0;
         phase_ff <= vosd_pkg::PH_HIDDEN;
         elapsed_ff <= '0;
         sop_ff <= '0;
         soff_ff <= vosd_pkg::HIDDEN_OFFSET;
         step_ff <= STEP_RESET;
         mute_ff <= 1'b0;
         last_ff <= STEP_RESET;
         en_ff <= 1'b1;
         intro_ff <= 22'd220000;
         hold_ff <= 22'd1100000;
         outro_ff <= 22'd200000;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         go_ff <= go_in;
         cap_intro_ff <= cap_intro_in;
         phase_ff <= phase_in;
         elapsed_ff <= elapsed_in;
         sop_ff <= sop_in;
         soff_ff <= soff_in;
         step_ff <= step_in;
         mute_ff <= mute_in;
         last_ff <= last_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               vosd_pkg::CSR_ENABLE: en_ff <= csr_data[0];
               vosd_pkg::CSR_INTRO:  intro_ff <= csr_data;
               vosd_pkg::CSR_HOLD:   hold_ff <= csr_data;
               vosd_pkg::CSR_OUTRO:  outro_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_op_ff <= pose_rsp.op;
         rsp_off_ff <= pose_rsp.off;
         rsp_phase_ff <= phase_ff;
         rsp_step_ff <= step_ff;
         rsp_mute_ff <= mute_ff;
         rsp_bar_ff <= mute_ff ? 8'd0 : bar_lut[step_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_opacity = rsp_op_ff;
   assign rsp_offset_y = rsp_off_ff;
   assign rsp_phase = rsp_phase_ff;
   assign rsp_volume_step = rsp_step_ff;
   assign rsp_is_muted = rsp_mute_ff;
   assign rsp_bar_fill = rsp_bar_ff;

`ifndef SYNTHESIS
   a_hidden_pose: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == vosd_pkg::PH_HIDDEN |->
         rsp_opacity == 17'd0 && rsp_offset_y == vosd_pkg::HIDDEN_OFFSET)
      else $error("hidden result with nonzero pose");
   a_hold_pose: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == vosd_pkg::PH_HOLD |->
         rsp_opacity == vosd_pkg::ONE_Q16 && rsp_offset_y == 13'sd0)
      else $error("hold result not fully shown");
   a_pose_busy: assert property (@(posedge clock) disable iff (reset)
      pose_busy |-> st_ff == S_CAP || st_ff == S_FIN)
      else $error("pose unit running outside capture or final pass");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_volume_step <= STEP_MAX && rsp_opacity <= vosd_pkg::ONE_Q16)
      else $error("result out of range");
`endif

endmodule
`default_nettype wire

/* design/vosd_pose.sv */
// Pose unit: phase progress divide, Bezier ease bisection, cube and blend; all products share one multiplier.
// Depends on vosd_pkg.
`default_nettype none
module vosd_pose #(
   parameter int EASE_ITERATIONS = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   go,
   input  vosd_pkg::pose_req_type req,
   output logic                  done,
   output logic                  busy,
   output vosd_pkg::pose_rsp_type rsp
);

   localparam int IW = $clog2(EASE_ITERATIONS);

   localparam logic [2:0] P_IDLE  = 3'd0;
   localparam logic [2:0] P_DIV   = 3'd1;
   localparam logic [2:0] P_EASE  = 3'd2;
   localparam logic [2:0] P_CUBE  = 3'd3;
   localparam logic [2:0] P_BLEND = 3'd4;
   localparam logic [2:0] P_DONE  = 3'd5;

   localparam logic [2:0] M_SU  = 3'd0;
   localparam logic [2:0] M_SU2 = 3'd1;
   localparam logic [2:0] M_S2U = 3'd2;
   localparam logic [2:0] M_SQ  = 3'd3;
   localparam logic [2:0] M_S3  = 3'd4;
   localparam logic [2:0] M_A1  = 3'd5;
   localparam logic [2:0] M_A2  = 3'd6;
   localparam logic [2:0] M_CMP = 3'd7;

   logic [2:0]  pst_ff, pst_in;
   logic [2:0]  sub_ff, sub_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;
   logic [IW-1:0] iter_ff, iter_in;
   vosd_pkg::pose_req_type req_ff, req_in;
   logic [21:0] rem_ff, rem_in;
   logic [16:0] t_ff, t_in, s_ff, s_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [33:0] p_ff, p_in, acc_ff, acc_in;
   logic [16:0] su2_ff, su2_in, s2u_ff, s2u_in, s3_ff, s3_in, e_ff, e_in;
   logic [18:0] x_ff, x_in;
   vosd_pkg::pose_rsp_type rsp_ff, rsp_in;

   logic [33:0] mul_a;
   logic [16:0] mul_b;
   logic [50:0] prod;

   assign prod = 51'(mul_a) * 51'(mul_b);

   always_comb begin
      logic [16:0] u;
      logic [22:0] rem2;
      logic        ge;
      logic [34:0] sum;
      logic [18:0] d;
      logic [16:0] nlo, nhi;
      logic [17:0] mid;
      logic signed [17:0] dop;
      logic signed [13:0] doff;
      logic [16:0] mag_op;
      logic [13:0] mag_off;
      logic [34:0] rnd;
      logic [17:0] r;
      logic [17:0] op_w;
      logic signed [13:0] off_w;
      pst_in = pst_ff;
      sub_in = sub_ff;
      div_cnt_in = div_cnt_ff;
      iter_in = iter_ff;
      req_in = req_ff;
      rem_in = rem_ff;
      t_in = t_ff;
      s_in = s_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      p_in = p_ff;
      acc_in = acc_ff;
      su2_in = su2_ff;
      s2u_in = s2u_ff;
      s3_in = s3_ff;
      e_in = e_ff;
      x_in = x_ff;
      rsp_in = rsp_ff;
      mul_a = '0;
      mul_b = '0;
      u = vosd_pkg::ONE_Q16 - s_ff;
      rem2 = {rem_ff, 1'b0};
      ge = rem2 >= {1'b0, req_ff.len};
      sum = '0;
      d = '0;
      nlo = lo_ff;
      nhi = hi_ff;
      mid = '0;
      dop = '0;
      doff = '0;
      mag_op = '0;
      mag_off = '0;
      rnd = '0;
      r = '0;
      op_w = '0;
      off_w = '0;
      unique case (pst_ff)
         P_IDLE: begin
            if (go) begin
               req_in = req;
               if (req.phase == vosd_pkg::PH_HIDDEN) begin
                  rsp_in.op = '0;
                  rsp_in.off = vosd_pkg::HIDDEN_OFFSET;
                  pst_in = P_DONE;
               end else if (req.phase == vosd_pkg::PH_HOLD) begin
                  rsp_in.op = vosd_pkg::ONE_Q16;
                  rsp_in.off = '0;
                  pst_in = P_DONE;
               end else if (req.elapsed >= req.len) begin
                  t_in = vosd_pkg::ONE_Q16;
                  s_in = vosd_pkg::ONE_Q16;
                  lo_in = '0;
                  hi_in = vosd_pkg::ONE_Q16;
                  iter_in = '0;
                  sub_in = M_SU;
                  pst_in = P_EASE;
               end else begin
                  rem_in = req.elapsed;
                  t_in = '0;
                  div_cnt_in = '0;
                  pst_in = P_DIV;
               end
            end
         end
         P_DIV: begin
            rem_in = ge ? 22'(rem2 - {1'b0, req_ff.len}) : rem2[21:0];
            t_in = {t_ff[15:0], ge};
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd15) begin
               s_in = {t_ff[15:0], ge};
               lo_in = '0;
               hi_in = vosd_pkg::ONE_Q16;
               iter_in = '0;
               sub_in = M_SU;
               pst_in = P_EASE;
            end
         end
         P_EASE: begin
            sub_in = sub_ff + 3'd1;
            case (sub_ff)
               M_SU: begin
                  mul_a = 34'(s_ff);
                  mul_b = u;
                  p_in = prod[33:0];
               end
               M_SU2: begin
                  mul_a = p_ff;
                  mul_b = u;
                  su2_in = prod[48:32];
               end
               M_S2U: begin
                  mul_a = p_ff;
                  mul_b = s_ff;
                  s2u_in = prod[48:32];
               end
               M_SQ: begin
                  mul_a = 34'(s_ff);
                  mul_b = s_ff;
                  p_in = prod[33:0];
               end
               M_S3: begin
                  mul_a = p_ff;
                  mul_b = s_ff;
                  s3_in = prod[48:32];
               end
               M_A1: begin
                  mul_a = 34'(su2_ff);
                  mul_b = vosd_pkg::COEF_SU2;
                  acc_in = prod[33:0];
               end
               M_A2: begin
                  mul_a = 34'(s2u_ff);
                  mul_b = vosd_pkg::COEF_S2U;
                  sum = {1'b0, acc_ff} + prod[34:0];
                  x_in = sum[34:16] + 19'(s3_ff);
               end
               default: begin
                  d = (x_ff > 19'(t_ff)) ? x_ff - 19'(t_ff) : 19'(t_ff) - x_ff;
                  if (d <= vosd_pkg::EASE_TOL) begin
                     sub_in = M_SU;
                     pst_in = P_CUBE;
                  end else begin
                     if (x_ff < 19'(t_ff)) nlo = s_ff;
                     else nhi = s_ff;
                     mid = 18'(nlo) + 18'(nhi);
                     lo_in = nlo;
                     hi_in = nhi;
                     s_in = mid[17:1];
                     sub_in = M_SU;
                     if (iter_ff == IW'(EASE_ITERATIONS - 1)) pst_in = P_CUBE;
                     else iter_in = iter_ff + 1'b1;
                  end
               end
            endcase
         end
         P_CUBE: begin
            mul_b = u;
            if (sub_ff == M_SU) begin
               mul_a = 34'(u);
               p_in = prod[33:0];
               sub_in = M_SU2;
            end else begin
               mul_a = p_ff;
               e_in = vosd_pkg::ONE_Q16 - prod[48:32];
               sub_in = M_SU;
               pst_in = P_BLEND;
            end
         end
         P_BLEND: begin
            mul_b = e_ff;
            if (sub_ff == M_SU) begin
               dop = ((req_ff.phase == vosd_pkg::PH_INTRO) ? 18'sd65536 : 18'sd0)
                     - $signed({1'b0, req_ff.start_op});
               mag_op = dop[17] ? 17'(-dop) : 17'(dop);
               mul_a = 34'(mag_op);
               rnd = prod[34:0] + 35'd32768;
               r = 18'(rnd[34:16]);
               op_w = dop[17] ? {1'b0, req_ff.start_op} - r : {1'b0, req_ff.start_op} + r;
               rsp_in.op = op_w[16:0];
               sub_in = M_SU2;
            end else begin
               doff = ((req_ff.phase == vosd_pkg::PH_INTRO) ? 14'sd0 : -14'sd3072)
                      - 14'(req_ff.start_off);
               mag_off = doff[13] ? 14'(-doff) : 14'(doff);
               mul_a = 34'(mag_off);
               rnd = prod[34:0] + 35'd32768;
               r = 18'(rnd[34:16]);
               off_w = doff[13] ? 14'(req_ff.start_off) - $signed(14'(r))
                                : 14'(req_ff.start_off) + $signed(14'(r));
               rsp_in.off = off_w[12:0];
               sub_in = M_SU;
               pst_in = P_DONE;
            end
         end
         P_DONE: pst_in = P_IDLE;
         default: pst_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff <= P_IDLE;
         sub_ff <= M_SU;
         div_cnt_ff <= '0;
         iter_ff <= '0;
      end else begin
         pst_ff <= pst_in;
         sub_ff <= sub_in;
         div_cnt_ff <= div_cnt_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rem_ff <= rem_in;
      t_ff <= t_in;
      s_ff <= s_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      p_ff <= p_in;
      acc_ff <= acc_in;
      su2_ff <= su2_in;
      s2u_ff <= s2u_in;
      s3_ff <= s3_in;
      e_ff <= e_in;
      x_ff <= x_in;
      rsp_ff <= rsp_in;
   end

   assign done = pst_ff == P_DONE;
   assign busy = pst_ff != P_IDLE;
   assign rsp = rsp_ff;

endmodule
`default_nettype wire

/* sim/volume_osd_step_and_fade_controller_core_tb.sv */
// Testbench for the volume overlay step and fade controller core.
// Drives directed and random items plus register phases, checks every result against a
// built-in predictor or, for the first directed items, a fixed expected view. Depends on vosd_pkg and the core RTL.
`timescale 1ns / 1ps
module volume_osd_step_and_fade_controller_core_tb;

   localparam int STEPS = 16;
   localparam int EASE_IT = 10;
   localparam int SETTLE = 300;
   localparam longint LIMIT = 3000000;

   typedef struct packed {
      logic [16:0]        op;
      logic signed [12:0] off;
      logic [1:0]         ph;
      logic [4:0]         step;
      logic               muted;
      logic [7:0]         bar;
   } osd_view_type;

   typedef struct packed {
      logic [2:0]   kind;
      logic [4:0]   rs;
      logic         rm;
      logic         typed;
      osd_view_type view;
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall, req_report_muted;
   logic [2:0] req_kind;
   logic [4:0] req_report_step;
   logic rsp_valid, rsp_stall, rsp_is_muted;
   logic [16:0] rsp_opacity;
   logic signed [12:0] rsp_offset_y;
   logic [1:0] rsp_phase;
   logic [4:0] rsp_volume_step;
   logic [7:0] rsp_bar_fill;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [21:0] csr_data;

   volume_osd_step_and_fade_controller_core u_top (.*);

   // predictor state
   logic        cfg_en;
   logic [21:0] cfg_intro, cfg_hold, cfg_outro;
   logic [1:0]  osd_phase;
   logic [21:0] osd_elapsed;
   int          osd_start_op, osd_start_off;
   logic [4:0]  osd_step, osd_last;
   logic        osd_muted;

   osd_view_type pending_views[$];
   int  mismatches, items_sent, results_seen, stall_left;
   bit  quiet, hold_req;
   longint cycles;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [16:0] ease_q16(logic [16:0] t);
      longint unsigned lo, hi, s, u, p, su2, s2u, s3, x, d;
      lo = 0; hi = 65536; s = t;
      for (int i = 0; i < EASE_IT; i++) begin
         u = 65536 - s;
         p = s * u;
         su2 = (p * u) >> 32;
         s2u = (p * s) >> 32;
         s3 = (s * s * s) >> 32;
         x = ((43254 * su2 + 70779 * s2u) >> 16) + s3;
         d = (x > t) ? x - t : t - x;
         if (d <= 3) break;
         if (x < t) lo = s; else hi = s;
         s = (lo + hi) >> 1;
      end
      u = 65536 - s;
      return 17'(65536 - ((u * u * u) >> 32));
   endfunction

   function automatic int blend(int a, int b, int e);
      longint prod, mag, r;
      prod = longint'(b - a) * e;
      mag = (prod < 0) ? -prod : prod;
      r = (mag + 32768) >>> 16;
      return (prod < 0) ? a - int'(r) : a + int'(r);
   endfunction

   task automatic current_pose(output int op, output int off);
      longint unsigned q, len;
      logic [16:0] t, e;
      int to_op, to_off;
      if (osd_phase == vosd_pkg::PH_HIDDEN) begin
         op = 0; off = -3072; return;
      end
      if (osd_phase == vosd_pkg::PH_HOLD) begin
         op = 65536; off = 0; return;
      end
      if (osd_phase == vosd_pkg::PH_INTRO) begin
         len = cfg_intro; to_op = 65536; to_off = 0;
      end else begin
         len = cfg_outro; to_op = 0; to_off = -3072;
      end
      if (len == 0) t = 17'd65536;
      else begin
         q = (longint'(osd_elapsed) << 16) / len;
         t = (q > 65536) ? 17'd65536 : 17'(q);
      end
      e = ease_q16(t);
      op = blend(osd_start_op, to_op, e);
      off = blend(osd_start_off, to_off, e);
   endtask

   task automatic enter_phase(logic [1:0] p);
      int op, off;
      current_pose(op, off);
      osd_start_op = op;
      osd_start_off = off;
      osd_phase = p;
      osd_elapsed = 0;
   endtask

   task automatic unmute_restore();
      if (osd_muted) begin
         osd_muted = 0;
         osd_step = osd_last;
      end
   endtask

   task automatic predict_view(logic [2:0] kind, logic [4:0] rs, logic rm,
                               output osd_view_type v);
      int op, off;
      if (kind == vosd_pkg::KIND_REPORT) begin
         osd_step = (rs > STEPS) ? 5'(STEPS) : rs;
         osd_muted = rm;
         if (osd_step > 0) osd_last = osd_step;
      end else if (cfg_en && kind == vosd_pkg::KIND_TICK) begin
         if (osd_elapsed < vosd_pkg::ELAPSED_MAX) osd_elapsed++;
         if (osd_phase == vosd_pkg::PH_INTRO && osd_elapsed >= cfg_intro)
            enter_phase(vosd_pkg::PH_HOLD);
         if (osd_phase == vosd_pkg::PH_HOLD && osd_elapsed >= cfg_hold)
            enter_phase(vosd_pkg::PH_OUTRO);
         if (osd_phase == vosd_pkg::PH_OUTRO && osd_elapsed >= cfg_outro)
            osd_phase = vosd_pkg::PH_HIDDEN;
      end else if (cfg_en && kind >= vosd_pkg::KIND_UP && kind <= vosd_pkg::KIND_MUTE) begin
         if (kind == vosd_pkg::KIND_UP) begin
            unmute_restore();
            if (osd_step < STEPS) osd_step++;
            osd_last = osd_step;
         end else if (kind == vosd_pkg::KIND_DOWN) begin
            unmute_restore();
            if (osd_step > 0) osd_step--;
            if (osd_step > 0) osd_last = osd_step;
         end else begin
            osd_muted = ~osd_muted;
            if (!osd_muted && osd_step == 0) osd_step = osd_last;
         end
         if (osd_phase == vosd_pkg::PH_HIDDEN || osd_phase == vosd_pkg::PH_OUTRO)
            enter_phase(vosd_pkg::PH_INTRO);
         else if (osd_phase == vosd_pkg::PH_HOLD) osd_elapsed = 0;
      end
      current_pose(op, off);
      v.op = 17'(op);
      v.off = 13'(off);
      v.ph = osd_phase;
      v.step = osd_step;
      v.muted = osd_muted;
      v.bar = osd_muted ? 8'd0 : 8'((osd_step * 240 + STEPS / 2) / STEPS);
   endtask

   task automatic send_item(logic [2:0] kind, logic [4:0] rs, logic rm,
                            logic typed, osd_view_type typed_view);
      osd_view_type v;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_report_step <= rs;
      req_report_muted <= rm;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_view(kind, rs, rm, v);
      pending_views.push_back(typed ? typed_view : v);
      items_sent++;
   endtask

   task automatic random_item();
      int r;
      logic [2:0] k;
      r = $urandom_range(0, 99);
      if (r < 55) k = vosd_pkg::KIND_TICK;
      else if (r < 80) k = 3'($urandom_range(1, 3));
      else if (r < 92) k = vosd_pkg::KIND_REPORT;
      else k = 3'($urandom_range(5, 7));
      send_item(k, 5'($urandom), 1'($urandom), 1'b0, '0);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [21:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         vosd_pkg::CSR_ENABLE: cfg_en = data[0];
         vosd_pkg::CSR_INTRO:  cfg_intro = data;
         vosd_pkg::CSR_HOLD:   cfg_hold = data;
         vosd_pkg::CSR_OUTRO:  cfg_outro = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_config(logic en, logic [21:0] ti, logic [21:0] th, logic [21:0] to);
      csr_write(vosd_pkg::CSR_ENABLE, {21'd0, en});
      csr_write(vosd_pkg::CSR_INTRO, ti);
      csr_write(vosd_pkg::CSR_HOLD, th);
      csr_write(vosd_pkg::CSR_OUTRO, to);
      csr_write(3'($urandom_range(4, 7)), 22'($urandom));
   endtask

   // receiver stall pattern
   initial begin
      rsp_stall = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else if (hold_req) begin
            hold_req = 0;
            stall_left = 399;
            rsp_stall <= 1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      osd_view_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transfer at cycle %0d", cycles);
         end else begin
            w = pending_views.pop_front();
            if (rsp_opacity !== w.op || rsp_offset_y !== w.off || rsp_phase !== w.ph ||
                rsp_volume_step !== w.step || rsp_is_muted !== w.muted ||
                rsp_bar_fill !== w.bar) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch @%0d exp op=%0d off=%0d ph=%0d st=%0d mu=%0d bar=%0d",
                           cycles, w.op, w.off, w.ph, w.step, w.muted, w.bar,
                           " got op=%0d off=%0d ph=%0d st=%0d mu=%0d bar=%0d",
                           rsp_opacity, rsp_offset_y, rsp_phase, rsp_volume_step,
                           rsp_is_muted, rsp_bar_fill);
            end
         end
      end
   end

   row_type directed[18];

   initial begin
      logic [21:0] cfgs[10][4];
      reset = 1;
      req_valid = 0; req_kind = vosd_pkg::KIND_TICK; req_report_step = 0;
      req_report_muted = 0;
      csr_valid = 0; csr_index = vosd_pkg::CSR_ENABLE; csr_data = 0;
      quiet = 0; hold_req = 0; cycles = 0;
      mismatches = 0; items_sent = 0; results_seen = 0;
      cfg_en = 1; cfg_intro = 220000; cfg_hold = 1100000; cfg_outro = 200000;
      osd_phase = vosd_pkg::PH_HIDDEN; osd_elapsed = 0; osd_start_op = 0;
      osd_start_off = -3072;
      osd_step = 8; osd_last = 8; osd_muted = 0;

      directed = '{
         '{vosd_pkg::KIND_TICK,   5'd0,  1'b0, 1'b1,
           '{17'd0, -13'sd3072, vosd_pkg::PH_HIDDEN, 5'd8, 1'b0, 8'd120}},
         '{vosd_pkg::KIND_REPORT, 5'd31, 1'b1, 1'b1,
           '{17'd0, -13'sd3072, vosd_pkg::PH_HIDDEN, 5'd16, 1'b1, 8'd0}},
         '{vosd_pkg::KIND_REPORT, 5'd0,  1'b0, 1'b1,
           '{17'd0, -13'sd3072, vosd_pkg::PH_HIDDEN, 5'd0, 1'b0, 8'd0}},
         '{3'd5,                  5'd31, 1'b1, 1'b1,
           '{17'd0, -13'sd3072, vosd_pkg::PH_HIDDEN, 5'd0, 1'b0, 8'd0}},
         '{3'd7,                  5'd16, 1'b0, 1'b1,
           '{17'd0, -13'sd3072, vosd_pkg::PH_HIDDEN, 5'd0, 1'b0, 8'd0}},
         '{vosd_pkg::KIND_UP,     5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_DOWN,   5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_DOWN,   5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_MUTE,   5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_MUTE,   5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_TICK,   5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_TICK,   5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_MUTE,   5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_UP,     5'd0,  1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_REPORT, 5'd16, 1'b0, 1'b0, '0},
         '{vosd_pkg::KIND_UP,     5'd0,  1'b0, 1'b0, '0},
         '{3'd6,                  5'd5,  1'b1, 1'b0, '0},
         '{vosd_pkg::KIND_TICK,   5'd0,  1'b0, 1'b0, '0}
      };

      cfgs = '{
         '{22'd1, 22'd3, 22'd2, 22'd4},
         '{22'd1, 22'd1, 22'd1, 22'd1},
         '{22'd0, 22'd5, 22'd5, 22'd5},
         '{22'd1, 22'd12, 22'd6, 22'd9},
         '{22'd1, 22'd0, 22'd0, 22'd0},
         '{22'd1, 22'h3FFFFF, 22'd1, 22'h3FFFFF},
         '{22'd1, 22'd20, 22'd10, 22'd30},
         '{22'd1, 22'd2, 22'd40, 22'd3},
         '{22'd1, 22'd7, 22'd3, 22'd7},
         '{22'd1, 22'd4, 22'd5, 22'd6}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed[i])
         send_item(directed[i].kind, directed[i].rs, directed[i].rm,
                   directed[i].typed, directed[i].view);

      for (int ph = 0; ph < 10; ph++) begin
         drain();
         set_config(cfgs[ph][0][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
         if (ph == 9) quiet = 1;
         for (int n = 0; n < 74; n++) begin
            if (ph == 3 && n == 10) hold_req = 1;
            if (ph == 6 && n == 37) begin
               @(negedge clock);
               req_valid <= 0;
               while (pending_views.size() != 0) @(posedge clock);
            end
            random_item();
         end
      end

      @(negedge clock);
      req_valid <= 0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d items over 10 register settings, %0d results checked, %0d mismatches",
               items_sent, results_seen, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
